// ===== sv/rts_pkg.sv =====
// Shared types and constants for the remote frame transmitter.
// Used by the register file, the frame encoder, the sequencer and the top level. No dependencies.
`default_nettype none

package rts_pkg;

	localparam int HOLD_W      = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int ADDR_W      = 24;
	localparam int BUTTON_W    = 4;
	localparam int CODE_W      = 16;
	localparam int REPEAT_W    = 8;
	localparam int FRAME_W     = 56;
	localparam int BIT_IDX_W   = 6;
	localparam int SYNC_W      = 3;
	localparam int IN_DATA_W   = 56;
	localparam int OUT_DATA_W  = 24;

	localparam logic [7:0]        FRAME_KEY    = 8'hA7;
	localparam logic [SYNC_W-1:0] FIRST_SYNCS  = 3'd2;
	localparam logic [SYNC_W-1:0] REPEAT_SYNCS = 3'd7;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_WAKEUP_PULSE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAKEUP_SILENCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HW_SYNC        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SW_SYNC        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_SYMBOL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP      = 3'd5;

	localparam logic [HOLD_W-1:0] RST_WAKEUP_PULSE   = 17'd9415;
	localparam logic [HOLD_W-1:0] RST_WAKEUP_SILENCE = 17'd89565;
	localparam logic [HOLD_W-1:0] RST_HW_SYNC        = 17'd2560;
	localparam logic [HOLD_W-1:0] RST_SW_SYNC        = 17'd4550;
	localparam logic [HOLD_W-1:0] RST_HALF_SYMBOL    = 17'd640;
	localparam logic [HOLD_W-1:0] RST_FRAME_GAP      = 17'd30415;

	typedef struct packed {
		logic [HOLD_W-1:0] wakeup_pulse;
		logic [HOLD_W-1:0] wakeup_silence;
		logic [HOLD_W-1:0] hw_sync;
		logic [HOLD_W-1:0] sw_sync;
		logic [HOLD_W-1:0] half_symbol;
		logic [HOLD_W-1:0] frame_gap;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/rts_cfg.sv =====
// Timing register file for the remote frame transmitter.
// Depends on rts_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module rts_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rts_pkg::HOLD_W-1:0]    cfg_data,
	output rts_pkg::cfg_t                      cfg
);

	rts_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wakeup_pulse   <= rts_pkg::RST_WAKEUP_PULSE;
			cfg_q.wakeup_silence <= rts_pkg::RST_WAKEUP_SILENCE;
			cfg_q.hw_sync        <= rts_pkg::RST_HW_SYNC;
			cfg_q.sw_sync        <= rts_pkg::RST_SW_SYNC;
			cfg_q.half_symbol    <= rts_pkg::RST_HALF_SYMBOL;
			cfg_q.frame_gap      <= rts_pkg::RST_FRAME_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rts_pkg::CFG_WAKEUP_PULSE:   cfg_q.wakeup_pulse   <= cfg_data;
				rts_pkg::CFG_WAKEUP_SILENCE: cfg_q.wakeup_silence <= cfg_data;
				rts_pkg::CFG_HW_SYNC:        cfg_q.hw_sync        <= cfg_data;
				rts_pkg::CFG_SW_SYNC:        cfg_q.sw_sync        <= cfg_data;
				rts_pkg::CFG_HALF_SYMBOL:    cfg_q.half_symbol    <= cfg_data;
				rts_pkg::CFG_FRAME_GAP:      cfg_q.frame_gap      <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/rts_frame_enc.sv =====
// Builds the obfuscated 56-bit frame from address, button and rolling code.
// Pure combinational; depends on rts_pkg for widths and the key byte.
`default_nettype none

module rts_frame_enc (
	input  wire logic [rts_pkg::ADDR_W-1:0]   addr,
	input  wire logic [rts_pkg::BUTTON_W-1:0] button,
	input  wire logic [rts_pkg::CODE_W-1:0]   code,
	output logic      [rts_pkg::FRAME_W-1:0]  frame
);

	logic [7:0] raw [7];
	logic [7:0] obf [7];
	logic [7:0] ck_acc;

	always_comb begin
		raw[0] = rts_pkg::FRAME_KEY;
		raw[1] = {button, 4'h0};
		raw[2] = code[15:8];
		raw[3] = code[7:0];
		raw[4] = addr[23:16];
		raw[5] = addr[15:8];
		raw[6] = addr[7:0];

		// checksum: XOR of every nibble, placed in the low nibble of byte 1
		ck_acc = 8'h00;
		for (int i = 0; i < 7; i++) begin
			ck_acc = ck_acc ^ raw[i] ^ {4'h0, raw[i][7:4]};
		end
		raw[1] = raw[1] | {4'h0, ck_acc[3:0]};

		// running XOR with the previous obfuscated byte
		obf[0] = raw[0];
		for (int i = 1; i < 7; i++) begin
			obf[i] = raw[i] ^ obf[i-1];
		end

		frame = {obf[0], obf[1], obf[2], obf[3], obf[4], obf[5], obf[6]};
	end

endmodule

`default_nettype wire

// ===== sv/rts_seq.sv =====
// Line sequencer: input register, one-step state update, result register.
// Depends on rts_pkg and rts_frame_enc.
`default_nettype none

module rts_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rts_pkg::cfg_t                  cfg,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           in_action,
	input  wire logic [rts_pkg::ADDR_W-1:0]     in_addr,
	input  wire logic [rts_pkg::BUTTON_W-1:0]   in_button,
	input  wire logic [rts_pkg::CODE_W-1:0]     in_code,
	input  wire logic [rts_pkg::REPEAT_W-1:0]   in_repeat,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                out_level,
	output logic      [rts_pkg::HOLD_W-1:0]     out_hold,
	output logic                                out_finished,
	output logic                                out_rejected
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_WAKE_HIGH, PH_WAKE_LOW, PH_SYNC_HIGH, PH_SYNC_LOW,
		PH_SW_HIGH, PH_SW_LOW, PH_BIT_FIRST, PH_BIT_SECOND, PH_GAP
	} phase_t;

	localparam logic [rts_pkg::BIT_IDX_W-1:0] LAST_BIT =
		rts_pkg::BIT_IDX_W'(rts_pkg::FRAME_W - 1);

	// input stage
	logic                             valid_s1;
	logic                             action_s1;
	logic [rts_pkg::ADDR_W-1:0]       addr_s1;
	logic [rts_pkg::BUTTON_W-1:0]     button_s1;
	logic [rts_pkg::CODE_W-1:0]       code_s1;
	logic [rts_pkg::REPEAT_W-1:0]     repeat_s1;

	// result stage
	logic                             valid_s2;
	logic                             level_s2;
	logic [rts_pkg::HOLD_W-1:0]       hold_s2;
	logic                             fin_s2;
	logic                             rej_s2;

	// sequencer state
	phase_t                           phase_q;
	logic [rts_pkg::FRAME_W-1:0]      frame_q;
	logic [rts_pkg::SYNC_W-1:0]       sync_target_q;
	logic [rts_pkg::SYNC_W-1:0]       sync_count_q;
	logic [rts_pkg::BIT_IDX_W-1:0]    bit_idx_q;
	logic                             cur_bit_q;
	logic [rts_pkg::REPEAT_W-1:0]     sent_q;
	logic [rts_pkg::REPEAT_W-1:0]     wanted_q;

	// next-state and result
	phase_t                           phase_d;
	logic [rts_pkg::SYNC_W-1:0]       sync_target_d;
	logic [rts_pkg::SYNC_W-1:0]       sync_count_d;
	logic [rts_pkg::BIT_IDX_W-1:0]    bit_idx_d;
	logic                             cur_bit_d;
	logic [rts_pkg::REPEAT_W-1:0]     sent_d;
	logic [rts_pkg::REPEAT_W-1:0]     wanted_d;
	logic                             load_frame;
	logic                             res_level;
	logic [rts_pkg::HOLD_W-1:0]       res_hold;
	logic                             res_fin;
	logic                             res_rej;

	logic [rts_pkg::FRAME_W-1:0]      new_frame;
	logic [rts_pkg::BIT_IDX_W-1:0]    sel_pos;
	logic                             sel_bit;
	logic [rts_pkg::REPEAT_W-1:0]     sent_inc;
	logic                             advance;

	rts_frame_enc u_frame_enc (
		.addr   (addr_s1),
		.button (button_s1),
		.code   (code_s1),
		.frame  (new_frame)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// bit to send next: bit 0 after the software sync, else the one after bit_idx_q
	assign sel_pos  = (phase_q == PH_SW_LOW) ? LAST_BIT : (LAST_BIT - bit_idx_q - 1'b1);
	assign sel_bit  = frame_q[sel_pos];
	assign sent_inc = sent_q + 1'b1;

	always_comb begin
		phase_d       = phase_q;
		sync_target_d = sync_target_q;
		sync_count_d  = sync_count_q;
		bit_idx_d     = bit_idx_q;
		cur_bit_d     = cur_bit_q;
		sent_d        = sent_q;
		wanted_d      = wanted_q;
		load_frame    = 1'b0;
		res_level     = 1'b0;
		res_hold      = '0;
		res_fin       = 1'b0;
		res_rej       = 1'b0;

		if (!action_s1) begin
			if (phase_q != PH_IDLE) begin
				res_rej = 1'b1;
			end else begin
				load_frame    = 1'b1;
				wanted_d      = repeat_s1;
				sent_d        = '0;
				sync_target_d = rts_pkg::FIRST_SYNCS;
				sync_count_d  = '0;
				bit_idx_d     = '0;
				phase_d       = PH_WAKE_HIGH;
				res_level     = 1'b1;
				res_hold      = cfg.wakeup_pulse;
			end
		end else begin
			unique case (phase_q)
				PH_WAKE_HIGH: begin
					phase_d  = PH_WAKE_LOW;
					res_hold = cfg.wakeup_silence;
				end
				PH_WAKE_LOW: begin
					phase_d   = PH_SYNC_HIGH;
					res_level = 1'b1;
					res_hold  = cfg.hw_sync;
				end
				PH_SYNC_HIGH: begin
					sync_count_d = sync_count_q + 1'b1;
					phase_d      = PH_SYNC_LOW;
					res_hold     = cfg.hw_sync;
				end
				PH_SYNC_LOW: begin
					res_level = 1'b1;
					if (sync_count_q < sync_target_q) begin
						phase_d  = PH_SYNC_HIGH;
						res_hold = cfg.hw_sync;
					end else begin
						phase_d  = PH_SW_HIGH;
						res_hold = cfg.sw_sync;
					end
				end
				PH_SW_HIGH: begin
					bit_idx_d = '0;
					phase_d   = PH_SW_LOW;
					res_hold  = cfg.half_symbol;
				end
				PH_SW_LOW: begin
					cur_bit_d = sel_bit;
					phase_d   = PH_BIT_FIRST;
					res_level = !sel_bit;
					res_hold  = cfg.half_symbol;
				end
				PH_BIT_FIRST: begin
					phase_d   = PH_BIT_SECOND;
					res_level = cur_bit_q;
					res_hold  = cfg.half_symbol;
				end
				PH_BIT_SECOND: begin
					if (bit_idx_q < LAST_BIT) begin
						bit_idx_d = bit_idx_q + 1'b1;
						cur_bit_d = sel_bit;
						phase_d   = PH_BIT_FIRST;
						res_level = !sel_bit;
						res_hold  = cfg.half_symbol;
					end else begin
						phase_d  = PH_GAP;
						res_hold = cfg.frame_gap;
					end
				end
				PH_GAP: begin
					sent_d = sent_inc;
					if (sent_inc < wanted_q) begin
						sync_target_d = rts_pkg::REPEAT_SYNCS;
						sync_count_d  = '0;
						bit_idx_d     = '0;
						phase_d       = PH_SYNC_HIGH;
						res_level     = 1'b1;
						res_hold      = cfg.hw_sync;
					end else begin
						phase_d = PH_IDLE;
						res_fin = 1'b1;
					end
				end
				default: begin
					// expiry while idle
					phase_d = PH_IDLE;
					res_rej = 1'b1;
				end
			endcase
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= in_action;
			addr_s1   <= in_addr;
			button_s1 <= in_button;
			code_s1   <= in_code;
			repeat_s1 <= in_repeat;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_frame) begin
			frame_q <= new_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			level_s2      <= 1'b0;
			hold_s2       <= '0;
			fin_s2        <= 1'b0;
			rej_s2        <= 1'b0;
			phase_q       <= PH_IDLE;
			sync_target_q <= rts_pkg::FIRST_SYNCS;
			sync_count_q  <= '0;
			bit_idx_q     <= '0;
			cur_bit_q     <= 1'b0;
			sent_q        <= '0;
			wanted_q      <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2      <= 1'b1;
				level_s2      <= res_level;
				hold_s2       <= res_hold;
				fin_s2        <= res_fin;
				rej_s2        <= res_rej;
				phase_q       <= phase_d;
				sync_target_q <= sync_target_d;
				sync_count_q  <= sync_count_d;
				bit_idx_q     <= bit_idx_d;
				cur_bit_q     <= cur_bit_d;
				sent_q        <= sent_d;
				wanted_q      <= wanted_d;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign out_level    = level_s2;
	assign out_hold     = hold_s2;
	assign out_finished = fin_s2;
	assign out_rejected = rej_s2;

	a_fin_rej_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(fin_s2 && rej_s2))
		else $error("finished and rejected set together");

	a_done_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (fin_s2 || rej_s2)) |-> (hold_s2 == '0) && !level_s2)
		else $error("finished or rejected item carries a level or hold");

	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_fin) |=> (phase_q == PH_IDLE))
		else $error("sequencer not idle after finish");

	a_bit_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_idx_q <= LAST_BIT)
		else $error("bit index past end of frame");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready && !advance) |=> $stable(phase_q))
		else $error("state moved while the result stage was stalled");

endmodule

`default_nettype wire

// ===== sv/rts_remote_frame_transmitter_top.sv =====
// Remote frame transmitter top level: stream ports, timing registers, sequencer.
// Depends on rts_pkg, rts_cfg and rts_seq.
// Path: an accepted item goes through one input register and one result register,
// which drives the output.
// Throughput: one item per cycle; a stalled result stage holds the input register.
// Reset (arst_n low, asynchronous): sequencer idle, timing registers to defaults.
`default_nettype none

module rts_remote_frame_transmitter_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: remote_address[23:0], button[27:24], code[43:28],
	//        repeat_count[51:44], zero fill [55:52]
	input  wire logic [rts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: action (0 start, 1 hold time elapsed)
	input  wire logic                           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// tdata: line_level[0], hold_time_us[17:1], zero fill [23:18]
	output logic      [rts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// tlast: finished
	output logic                                m_axis_tlast,
	// tuser: rejected
	output logic                                m_axis_tuser,
	input  wire logic                           cfg_we,
	input  wire logic [rts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rts_pkg::HOLD_W-1:0]     cfg_data
);

	rts_pkg::cfg_t              cfg;
	logic                       level;
	logic [rts_pkg::HOLD_W-1:0] hold;

	rts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rts_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_action    (s_axis_tuser),
		.in_addr      (s_axis_tdata[23:0]),
		.in_button    (s_axis_tdata[27:24]),
		.in_code      (s_axis_tdata[43:28]),
		.in_repeat    (s_axis_tdata[51:44]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_level    (level),
		.out_hold     (hold),
		.out_finished (m_axis_tlast),
		.out_rejected (m_axis_tuser)
	);

	assign m_axis_tdata = {6'b0, hold, level};

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for rts_remote_frame_transmitter_top. A scoreboard class predicts every
// line level and hold time, and checks the results. Depends on rts_pkg and the top level.

module tb_top;

	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_EXPIRE = 1'b1;

	// indexes past the last register; writes to them must be dropped
	localparam logic [rts_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [rts_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam logic [rts_pkg::HOLD_W-1:0] HOLD_MAX = '1;
	localparam int ITEM_TARGET = 1850;
	localparam int ROUND_ITEMS = 150;

	typedef struct packed {
		logic                       level;
		logic [rts_pkg::HOLD_W-1:0] hold;
		logic                       fin;
		logic                       rej;
	} pulse_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WAKE_HIGH, ST_WAKE_LOW, ST_SYNC_HIGH, ST_SYNC_LOW,
		ST_SW_HIGH, ST_SW_LOW, ST_BIT_FIRST, ST_BIT_SECOND, ST_GAP
	} line_state_t;

	class pulse_scoreboard;
		logic [rts_pkg::HOLD_W-1:0]    timing [0:5];
		line_state_t                   state;
		logic [rts_pkg::FRAME_W-1:0]   frame;
		logic [rts_pkg::SYNC_W-1:0]    sync_goal;
		logic [rts_pkg::SYNC_W-1:0]    syncs_done;
		logic [rts_pkg::BIT_IDX_W-1:0] bit_pos;
		logic                          cur_bit;
		logic [rts_pkg::REPEAT_W-1:0]  frames_done;
		logic [rts_pkg::REPEAT_W-1:0]  frames_total;
		pulse_t                        expected_pulses [$];
		int                            mismatch_count;

		function new();
			timing[rts_pkg::CFG_WAKEUP_PULSE]   = rts_pkg::RST_WAKEUP_PULSE;
			timing[rts_pkg::CFG_WAKEUP_SILENCE] = rts_pkg::RST_WAKEUP_SILENCE;
			timing[rts_pkg::CFG_HW_SYNC]        = rts_pkg::RST_HW_SYNC;
			timing[rts_pkg::CFG_SW_SYNC]        = rts_pkg::RST_SW_SYNC;
			timing[rts_pkg::CFG_HALF_SYMBOL]    = rts_pkg::RST_HALF_SYMBOL;
			timing[rts_pkg::CFG_FRAME_GAP]      = rts_pkg::RST_FRAME_GAP;
			state = ST_IDLE;
			frame = '0;
			sync_goal = rts_pkg::FIRST_SYNCS;
			syncs_done = '0;
			bit_pos = '0;
			cur_bit = 1'b0;
			frames_done = '0;
			frames_total = '0;
			mismatch_count = 0;
		endfunction

		function void set_timing(logic [rts_pkg::CFG_IDX_W-1:0] idx,
				logic [rts_pkg::HOLD_W-1:0] val);
			if (idx <= rts_pkg::CFG_FRAME_GAP) begin
				timing[idx] = val;
			end
		endfunction

		function bit idle();
			return state == ST_IDLE;
		endfunction

		function int pending();
			return expected_pulses.size();
		endfunction

		function pulse_t line_out(logic level, logic [rts_pkg::HOLD_W-1:0] hold, logic fin,
				logic rej);
			pulse_t p;
			p.level = level;
			p.hold = hold;
			p.fin = fin;
			p.rej = rej;
			return p;
		endfunction

		// key byte, button with nibble checksum, code big-endian, address; then chain XOR
		function logic [rts_pkg::FRAME_W-1:0] build_frame(logic [rts_pkg::ADDR_W-1:0] addr,
				logic [rts_pkg::BUTTON_W-1:0] btn, logic [rts_pkg::CODE_W-1:0] code);
			logic [7:0] b [7];
			logic [7:0] ck;
			logic [rts_pkg::FRAME_W-1:0] f;
			b[0] = rts_pkg::FRAME_KEY;
			b[1] = {btn, 4'h0};
			b[2] = code[15:8];
			b[3] = code[7:0];
			b[4] = addr[23:16];
			b[5] = addr[15:8];
			b[6] = addr[7:0];
			ck = '0;
			for (int i = 0; i < 7; i++) begin
				ck = ck ^ b[i] ^ (b[i] >> 4);
			end
			b[1][3:0] = ck[3:0];
			for (int i = 1; i < 7; i++) begin
				b[i] = b[i] ^ b[i-1];
			end
			f = '0;
			for (int i = 0; i < 7; i++) begin
				f = {f[rts_pkg::FRAME_W-9:0], b[i]};
			end
			return f;
		endfunction

		// first half of a Manchester bit: a one goes low first
		function pulse_t first_half();
			cur_bit = frame[rts_pkg::FRAME_W - 1 - bit_pos];
			state = ST_BIT_FIRST;
			return line_out(!cur_bit, timing[rts_pkg::CFG_HALF_SYMBOL], 1'b0, 1'b0);
		endfunction

		function void note_item(logic act, logic [rts_pkg::IN_DATA_W-1:0] data);
			pulse_t p;
			if (act == ACT_START) begin
				if (state != ST_IDLE) begin
					p = line_out(1'b0, '0, 1'b0, 1'b1);
				end else begin
					frame = build_frame(data[23:0], data[27:24], data[43:28]);
					frames_total = data[51:44];
					frames_done = '0;
					sync_goal = rts_pkg::FIRST_SYNCS;
					syncs_done = '0;
					bit_pos = '0;
					state = ST_WAKE_HIGH;
					p = line_out(1'b1, timing[rts_pkg::CFG_WAKEUP_PULSE], 1'b0, 1'b0);
				end
			end else begin
				case (state)
					ST_WAKE_HIGH: begin
						state = ST_WAKE_LOW;
						p = line_out(1'b0, timing[rts_pkg::CFG_WAKEUP_SILENCE], 1'b0, 1'b0);
					end
					ST_WAKE_LOW: begin
						state = ST_SYNC_HIGH;
						p = line_out(1'b1, timing[rts_pkg::CFG_HW_SYNC], 1'b0, 1'b0);
					end
					ST_SYNC_HIGH: begin
						syncs_done = syncs_done + 1'b1;
						state = ST_SYNC_LOW;
						p = line_out(1'b0, timing[rts_pkg::CFG_HW_SYNC], 1'b0, 1'b0);
					end
					ST_SYNC_LOW: begin
						if (syncs_done < sync_goal) begin
							state = ST_SYNC_HIGH;
							p = line_out(1'b1, timing[rts_pkg::CFG_HW_SYNC], 1'b0, 1'b0);
						end else begin
							state = ST_SW_HIGH;
							p = line_out(1'b1, timing[rts_pkg::CFG_SW_SYNC], 1'b0, 1'b0);
						end
					end
					ST_SW_HIGH: begin
						bit_pos = '0;
						state = ST_SW_LOW;
						p = line_out(1'b0, timing[rts_pkg::CFG_HALF_SYMBOL], 1'b0, 1'b0);
					end
					ST_SW_LOW: begin
						p = first_half();
					end
					ST_BIT_FIRST: begin
						state = ST_BIT_SECOND;
						p = line_out(cur_bit, timing[rts_pkg::CFG_HALF_SYMBOL], 1'b0, 1'b0);
					end
					ST_BIT_SECOND: begin
						if (bit_pos < rts_pkg::FRAME_W - 1) begin
							bit_pos = bit_pos + 1'b1;
							p = first_half();
						end else begin
							state = ST_GAP;
							p = line_out(1'b0, timing[rts_pkg::CFG_FRAME_GAP], 1'b0, 1'b0);
						end
					end
					ST_GAP: begin
						frames_done = frames_done + 1'b1;
						if (frames_done < frames_total) begin
							sync_goal = rts_pkg::REPEAT_SYNCS;
							syncs_done = '0;
							bit_pos = '0;
							state = ST_SYNC_HIGH;
							p = line_out(1'b1, timing[rts_pkg::CFG_HW_SYNC], 1'b0, 1'b0);
						end else begin
							state = ST_IDLE;
							p = line_out(1'b0, '0, 1'b1, 1'b0);
						end
					end
					default: begin
						// expiry with nothing in progress
						state = ST_IDLE;
						p = line_out(1'b0, '0, 1'b0, 1'b1);
					end
				endcase
			end
			expected_pulses.push_back(p);
		endfunction

		function void check_pulse(pulse_t got);
			pulse_t want;
			if (expected_pulses.size() == 0) begin
				$display("%0t: result with nothing expected: level %0b hold %0d fin %0b rej %0b",
					$time, got.level, got.hold, got.fin, got.rej);
				mismatch_count++;
				return;
			end
			want = expected_pulses.pop_front();
			if (got.level !== want.level) begin
				$display("%0t: line_level expected %0b actual %0b", $time, want.level, got.level);
				mismatch_count++;
			end
			if (got.hold !== want.hold) begin
				$display("%0t: hold_time_us expected %0d actual %0d", $time, want.hold, got.hold);
				mismatch_count++;
			end
			if (got.fin !== want.fin) begin
				$display("%0t: finished expected %0b actual %0b", $time, want.fin, got.fin);
				mismatch_count++;
			end
			if (got.rej !== want.rej) begin
				$display("%0t: rejected expected %0b actual %0b", $time, want.rej, got.rej);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [rts_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [rts_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [rts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rts_pkg::HOLD_W-1:0] cfg_data = '0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int items_sent = 0;
	pulse_scoreboard board;

	rts_remote_frame_transmitter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_pulse(pulse_t'({m_axis_tdata[0], m_axis_tdata[17:1],
				m_axis_tlast, m_axis_tuser}));
		end
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [rts_pkg::IN_DATA_W-1:0] rand_fields();
		return {4'h0, 20'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [rts_pkg::IN_DATA_W-1:0] start_fields(
			logic [rts_pkg::ADDR_W-1:0] addr, logic [rts_pkg::BUTTON_W-1:0] btn,
			logic [rts_pkg::CODE_W-1:0] code, logic [rts_pkg::REPEAT_W-1:0] rep);
		return {4'h0, rep, code, btn, addr};
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(logic act, logic [rts_pkg::IN_DATA_W-1:0] data);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_item(act, data);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
	endtask

	// step the line until the transmission ends; sprinkle starts that arrive while busy
	task automatic finish_frames(int noise_pct, int pause_at);
		int n;
		n = 0;
		while (!board.idle()) begin
			n++;
			if (n == pause_at) drain_results();
			if ($urandom_range(99) < noise_pct) begin
				send_item(ACT_START, rand_fields());
			end else begin
				send_item(ACT_EXPIRE, rand_fields());
			end
		end
	endtask

	task automatic write_reg(logic [rts_pkg::CFG_IDX_W-1:0] idx,
			logic [rts_pkg::HOLD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		board.set_timing(idx, val);
	endtask

	task automatic program_timing(int kind);
		logic [rts_pkg::CFG_IDX_W-1:0] idx;
		logic [rts_pkg::HOLD_W-1:0] v;
		for (idx = rts_pkg::CFG_WAKEUP_PULSE; idx <= rts_pkg::CFG_FRAME_GAP; idx++) begin
			case (kind)
				0: v = rts_pkg::HOLD_W'($urandom_range(1, 64));
				1: v = 17'd1;
				2: v = HOLD_MAX;
				3: v = '0;
				default: v = rts_pkg::HOLD_W'($urandom_range(1, HOLD_MAX));
			endcase
			write_reg(idx, v);
		end
		write_reg(CFG_SPARE_LO, rts_pkg::HOLD_W'($urandom));
		write_reg(CFG_SPARE_HI, rts_pkg::HOLD_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [rts_pkg::IN_DATA_W-1:0] d;
		int round;
		int round_end;
		board = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: expiry with nothing running, both field extremes, busy start
		send_item(ACT_EXPIRE, rand_fields());
		send_item(ACT_EXPIRE, start_fields('1, '1, '1, '1));
		send_item(ACT_START, start_fields('0, '0, '0, '0));
		send_item(ACT_START, start_fields('1, '1, '1, '1));
		finish_frames(0, 0);
		// one frame for a count of one; hold off midway until the output is empty
		send_item(ACT_START, start_fields('1, '1, '1, 8'd1));
		finish_frames(0, 40);
		// repeated frames with the longer sync run
		send_item(ACT_START, start_fields(24'h5A5A5A, 4'h2, 16'h1234, 8'd2));
		finish_frames(0, 0);

		round = 0;
		while (items_sent < ITEM_TARGET) begin
			drain_results();
			repeat (4) @(negedge clk);
			if (round > 0) program_timing(round % 5);
			case (round % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
				default: begin src_idle_pct = 17; sink_stall_pct = 17; end
			endcase
			round_end = items_sent + ROUND_ITEMS;
			while (items_sent < round_end) begin
				if ($urandom_range(99) < 20) begin
					send_item(ACT_EXPIRE, rand_fields());
				end else begin
					d = rand_fields();
					d[51:44] = ($urandom_range(7) == 0)
						? rts_pkg::REPEAT_W'($urandom_range(4, 6))
						: rts_pkg::REPEAT_W'($urandom_range(0, 3));
					send_item(ACT_START, d);
					finish_frames(3, ($urandom_range(3) == 0) ? $urandom_range(1, 150) : 0);
				end
			end
			round++;
		end

		drain_results();
		repeat (5) @(negedge clk);
		if (board.mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rts_pkg.sv
sv/rts_cfg.sv
sv/rts_frame_enc.sv
sv/rts_seq.sv
sv/rts_remote_frame_transmitter_top.sv
dv/tb_top.sv
